/* hw/rtl/cbgc_pkg.sv */
package cbgc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_AMOD,
        ST_CLR,
        ST_P_RD,
        ST_P_LD,
        ST_P_COL,
        ST_P_ROW,
        ST_P_WR,
        ST_P_MUL,
        ST_L_START,
        ST_L_SA,
        ST_L_SB,
        ST_L_SC,
        ST_C_RD,
        ST_C_WR,
        ST_C_CNT,
        ST_C_END,
        ST_OUT
    } state_t;

    localparam int CHUNK_W = 32;

    localparam logic [1:0] REG_MODULUS_M = 2'd0;
    localparam logic [1:0] REG_ROWS_N    = 2'd1;
    localparam logic [1:0] REG_TWIST_A   = 2'd2;
    localparam logic [1:0] REG_RADIUS_D  = 2'd3;

    function automatic logic [5:0] pop32(input logic [CHUNK_W-1:0] x);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            c = c + 6'(x[i]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/cayley_ball_growth_counter_unit.sv */
// Ball growth counter for Cayley graphs of Z_m x| Z_n. Each request on s_ carries one
// generator (tlast marks the last one of a set). A generator is split into a column
// and a row index (quotient by m, serial subtract) and stored; a dropped one is not
// stored. The final one runs the evaluation and gives one result on m_: it reduces a
// and clears the n rows, then per stored generator reduces its column and row modulo
// m and n and builds its per-row shift table (8-step modular multiply per row), then
// per level runs read-rotate-or on the ball memory and copies and popcounts the rows
// in 32-bit chunks, stopping early once all m*n elements are covered. The ball memory
// ports bound the level loop. A finished result waits in the output register while
// new generators load.
module cayley_ball_growth_counter_unit import cbgc_pkg::*; #(
    parameter int MAX_M = 256,
    parameter int MAX_N = 64,
    parameter int MAX_GENS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] gen_element
    input  logic        s_tlast,   // last_gen
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] ball_count, [29:15] prev_count,
                                   // [30] covered, [31] set_error
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int MW  = $clog2(MAX_M + 1);
    localparam int NW  = $clog2(MAX_N + 1);
    localparam int RA  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int GW  = $clog2(MAX_GENS + 1);
    localparam int GI  = (MAX_GENS > 1) ? $clog2(MAX_GENS) : 1;
    localparam int SA  = (MAX_GENS * MAX_N > 1) ? $clog2(MAX_GENS * MAX_N) : 1;
    localparam int TW  = $clog2(MAX_M * MAX_N + 1);
    localparam int ENW = RA + MW;
    localparam int NCH = (MAX_M + CHUNK_W - 1) / CHUNK_W;
    localparam int CKW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int WW  = NCH * CHUNK_W;

    state_t state_reg, state_next;

    logic [8:0] m_reg;
    logic [6:0] n_reg;
    logic [7:0] a_reg, d_reg;

    logic [MW-1:0] m_eff;
    logic [NW-1:0] n_eff;
    logic [TW-1:0] total;

    logic [GW-1:0]  gen_cnt_reg, gen_cnt_next;
    logic           drop_reg, drop_next;
    logic           last_reg, last_next;
    logic [13:0]    rem_reg, rem_next;
    logic [NW-1:0]  row_reg, row_next;
    logic [MW-1:0]  col_reg, col_next;
    logic [GW-1:0]  g_reg, g_next;
    logic [NW-1:0]  r_reg, r_next;
    logic [NW-1:0]  dr_reg, dr_next;
    logic [MW-1:0]  sh_reg, sh_next;
    logic [7:0]     amod_reg, amod_next;
    logic [MW-1:0]  res_reg, res_next;
    logic [2:0]     bit_reg, bit_next;
    logic [7:0]     lvl_reg, lvl_next;
    logic [TW-1:0]  cnt_reg, cnt_next;
    logic [TW-1:0]  prev_reg, prev_next;
    logic [TW-1:0]  acc_reg, acc_next;
    logic [WW-1:0]  word_reg, word_next;
    logic [CKW-1:0] chunk_reg, chunk_next;
    logic           m_valid_reg, m_valid_next;
    logic [31:0]    out_reg, out_next;

    // memories
    logic [MAX_M-1:0] now_mem  [MAX_N];
    logic [MAX_M-1:0] grow_mem [MAX_N];
    logic [ENW-1:0]   sh_mem   [MAX_GENS * MAX_N];
    logic [ENW-1:0]   gen_mem  [MAX_GENS];

    logic [MAX_M-1:0] now_q, grow_q, now_wdata, grow_wdata, rot_out;
    logic [ENW-1:0]   sh_q, gen_q, sh_wdata, gen_wdata;
    logic [RA-1:0]    now_raddr, grow_raddr, now_waddr, grow_waddr;
    logic [SA-1:0]    sh_raddr, sh_waddr;
    logic [GI-1:0]    gen_raddr, gen_waddr;
    logic             now_we, grow_we, sh_we, gen_we;

    logic [MW:0]   mul_a, mul_b;
    logic          accept;
    logic [SA-1:0] sh_addr;

    assign m_eff = (m_reg == 9'd0) ? MW'(1) :
                   (32'(m_reg) > MAX_M) ? MW'(MAX_M) : MW'(m_reg);
    assign n_eff = (n_reg == 7'd0) ? NW'(1) :
                   (32'(n_reg) > MAX_N) ? NW'(MAX_N) : NW'(n_reg);
    assign total = TW'(int'(m_eff) * int'(n_eff));

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign sh_addr  = SA'(int'(g_reg) * MAX_N + int'(r_reg));

    cbgc_rotor #(.BW(MAX_M), .MW(MW)) u_rotor (
        .row_in  (now_q),
        .m       (m_eff),
        .sh      (sh_reg),
        .row_out (rot_out)
    );

    always_ff @(posedge aclk) begin
        if (now_we) now_mem[now_waddr] <= now_wdata;
        if (grow_we) grow_mem[grow_waddr] <= grow_wdata;
        if (sh_we) sh_mem[sh_waddr] <= sh_wdata;
        if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
        now_q  <= now_mem[now_raddr];
        grow_q <= grow_mem[grow_raddr];
        sh_q   <= sh_mem[sh_raddr];
        gen_q  <= gen_mem[gen_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg <= 9'd1;
            n_reg <= 7'd1;
            a_reg <= 8'd1;
            d_reg <= 8'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODULUS_M: m_reg <= cfg_data;
                REG_ROWS_N:    n_reg <= cfg_data[6:0];
                REG_TWIST_A:   a_reg <= cfg_data[7:0];
                REG_RADIUS_D:  d_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_cnt_reg <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_cnt_reg <= gen_cnt_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        rem_reg   <= rem_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        g_reg     <= g_next;
        r_reg     <= r_next;
        dr_reg    <= dr_next;
        sh_reg    <= sh_next;
        amod_reg  <= amod_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        lvl_reg   <= lvl_next;
        cnt_reg   <= cnt_next;
        prev_reg  <= prev_next;
        acc_reg   <= acc_next;
        word_reg  <= word_next;
        chunk_reg <= chunk_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        gen_cnt_next = gen_cnt_reg;
        drop_next    = drop_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        g_next       = g_reg;
        r_next       = r_reg;
        dr_next      = dr_reg;
        sh_next      = sh_reg;
        amod_next    = amod_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        acc_next     = acc_reg;
        word_next    = word_reg;
        chunk_next   = chunk_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        now_we     = 1'b0;
        grow_we    = 1'b0;
        sh_we      = 1'b0;
        gen_we     = 1'b0;
        now_waddr  = r_reg[RA-1:0];
        grow_waddr = r_reg[RA-1:0];
        now_wdata  = grow_q;
        grow_wdata = (r_reg == '0) ? MAX_M'(1) : '0;
        now_raddr  = r_reg[RA-1:0];
        grow_raddr = r_reg[RA-1:0];
        sh_raddr   = sh_addr;
        sh_waddr   = sh_addr;
        sh_wdata   = {dr_reg[RA-1:0], sh_reg};
        gen_raddr  = g_reg[GI-1:0];
        gen_waddr  = gen_cnt_reg[GI-1:0];
        gen_wdata  = {row_reg[RA-1:0], MW'(rem_reg)};

        // one double-and-add step of sh * amod mod m
        mul_a = {res_reg, 1'b0};
        if (mul_a >= {1'b0, m_eff}) mul_a = mul_a - {1'b0, m_eff};
        mul_b = mul_a;
        if (amod_reg[bit_reg]) mul_b = mul_a + {1'b0, sh_reg};
        if (mul_b >= {1'b0, m_eff}) mul_b = mul_b - {1'b0, m_eff};

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_tlast;
                    if (32'(s_tdata[13:0]) >= 32'(total) ||
                        32'(gen_cnt_reg) >= MAX_GENS) begin
                        drop_next  = 1'b1;
                        state_next = s_tlast ? ST_AMOD : ST_IDLE;
                        amod_next  = a_reg;
                    end else begin
                        rem_next   = s_tdata[13:0];
                        row_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (32'(rem_reg) >= 32'(m_eff)) begin
                    rem_next = rem_reg - 14'(m_eff);
                    row_next = row_reg + NW'(1);
                end else begin
                    gen_we       = 1'b1;
                    gen_cnt_next = gen_cnt_reg + GW'(1);
                    amod_next    = a_reg;
                    state_next   = last_reg ? ST_AMOD : ST_IDLE;
                end
            end
            ST_AMOD: begin
                if (32'(amod_reg) >= 32'(m_eff)) begin
                    amod_next = amod_reg - 8'(m_eff);
                end else begin
                    r_next     = '0;
                    g_next     = '0;
                    lvl_next   = '0;
                    cnt_next   = TW'(1);
                    prev_next  = TW'(1);
                    state_next = ST_CLR;
                end
            end
            ST_CLR: begin
                now_we     = 1'b1;
                grow_we    = 1'b1;
                now_wdata  = grow_wdata;
                if (r_reg == n_eff - NW'(1)) begin
                    state_next = (gen_cnt_reg == '0) ? ST_L_START : ST_P_RD;
                end else begin
                    r_next = r_reg + NW'(1);
                end
            end
            ST_P_RD: state_next = ST_P_LD;
            ST_P_LD: begin
                col_next   = gen_q[MW-1:0];
                row_next   = NW'(gen_q[ENW-1:MW]);
                state_next = ST_P_COL;
            end
            ST_P_COL: begin
                if (col_reg >= m_eff) col_next = col_reg - m_eff;
                else state_next = ST_P_ROW;
            end
            ST_P_ROW: begin
                if (row_reg >= n_eff) begin
                    row_next = row_reg - n_eff;
                end else begin
                    dr_next    = row_reg;
                    sh_next    = col_reg;
                    r_next     = '0;
                    state_next = ST_P_WR;
                end
            end
            ST_P_WR: begin
                sh_we = 1'b1;
                if (r_reg == n_eff - NW'(1)) begin
                    g_next = g_reg + GW'(1);
                    if (g_reg + GW'(1) == gen_cnt_reg) state_next = ST_L_START;
                    else state_next = ST_P_RD;
                end else begin
                    res_next   = '0;
                    bit_next   = 3'd7;
                    state_next = ST_P_MUL;
                end
            end
            ST_P_MUL: begin
                res_next = mul_b[MW-1:0];
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) begin
                    sh_next    = mul_b[MW-1:0];
                    r_next     = r_reg + NW'(1);
                    dr_next    = (dr_reg + NW'(1) == n_eff) ? '0 : dr_reg + NW'(1);
                    state_next = ST_P_WR;
                end
            end
            ST_L_START: begin
                g_next = '0;
                r_next = '0;
                acc_next = '0;
                if (lvl_reg == d_reg) begin
                    state_next = ST_OUT;
                end else begin
                    lvl_next   = lvl_reg + 8'd1;
                    prev_next  = cnt_reg;
                    state_next = (gen_cnt_reg == '0) ? ST_C_RD : ST_L_SA;
                end
            end
            ST_L_SA: state_next = ST_L_SB;
            ST_L_SB: begin
                grow_raddr = sh_q[ENW-1:MW];
                sh_next    = sh_q[MW-1:0];
                dr_next    = NW'(sh_q[ENW-1:MW]);
                state_next = ST_L_SC;
            end
            ST_L_SC: begin
                grow_we    = 1'b1;
                grow_waddr = dr_reg[RA-1:0];
                grow_wdata = grow_q | rot_out;
                if (r_reg == n_eff - NW'(1)) begin
                    r_next = '0;
                    g_next = g_reg + GW'(1);
                    if (g_reg + GW'(1) == gen_cnt_reg) state_next = ST_C_RD;
                    else state_next = ST_L_SA;
                end else begin
                    r_next     = r_reg + NW'(1);
                    state_next = ST_L_SA;
                end
            end
            ST_C_RD: state_next = ST_C_WR;
            ST_C_WR: begin
                now_we     = 1'b1;
                word_next  = WW'(grow_q);
                chunk_next = '0;
                state_next = ST_C_CNT;
            end
            ST_C_CNT: begin
                acc_next   = acc_reg + TW'(pop32(word_reg[CHUNK_W-1:0]));
                word_next  = word_reg >> CHUNK_W;
                chunk_next = chunk_reg + CKW'(1);
                if (chunk_reg == CKW'(NCH - 1)) begin
                    if (r_reg == n_eff - NW'(1)) begin
                        state_next = ST_C_END;
                    end else begin
                        r_next     = r_reg + NW'(1);
                        state_next = ST_C_RD;
                    end
                end
            end
            ST_C_END: begin
                cnt_next = acc_reg;
                if (acc_reg == total && lvl_reg < d_reg) begin
                    // full coverage before the last level
                    prev_next  = total;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_L_START;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_next     = {drop_reg, (cnt_reg == total),
                                    15'(prev_reg), 15'(cnt_reg)};
                    gen_cnt_next = '0;
                    drop_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* hw/rtl/cbgc_rotor.sv */
// Cyclic rotation of the low m bits of a row toward higher bits by sh (sh < m).
module cbgc_rotor import cbgc_pkg::*; #(
    parameter int BW = 256,
    parameter int MW = 9
) (
    input  logic [BW-1:0] row_in,
    input  logic [MW-1:0] m,
    input  logic [MW-1:0] sh,
    output logic [BW-1:0] row_out
);

    logic [BW-1:0] mask;
    logic [MW-1:0] back;

    assign back    = m - sh;
    assign mask    = {BW{1'b1}} >> (MW'(BW) - m);
    assign row_out = ((row_in << sh) | (row_in >> back)) & mask;

endmodule

/* bench/tb_cayley_ball_growth_counter_unit.sv */
`timescale 1ns / 100ps

module tb_cayley_ball_growth_counter_unit;
    import cbgc_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [13:0] elem;
        logic        last;
    } gen_req_t;

    typedef struct {
        logic [14:0] ball;
        logic [14:0] prev;
        logic        cov;
        logic        err;
    } ball_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;

    cayley_ball_growth_counter_unit i_dut (.*);

    always #4 aclk = ~aclk;

    // register shadow
    logic [8:0] reg_m = 9'd1;
    logic [6:0] reg_n = 7'd1;
    logic [7:0] reg_a = 8'd1;
    logic [7:0] reg_d = 8'd1;

    // generator store of the model
    int unsigned gen_col [32];
    int unsigned gen_row [32];
    int unsigned gen_cnt = 0;
    bit          drop_seen = 0;
    logic [255:0] ball_now [64];
    logic [255:0] ball_nxt [64];

    gen_req_t  gen_pend [$];
    ball_res_t ball_exp [$];

    int  errors = 0;
    int  sent = 0;
    int  sets_done = 0;
    int  drops = 0;
    int  covers = 0;
    int  idle_cycles = 0;
    bit  no_idle = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;

    function automatic int unsigned eff_m();
        if (reg_m == 0) return 1;
        return (reg_m > 256) ? 256 : reg_m;
    endfunction

    function automatic int unsigned eff_n();
        if (reg_n == 0) return 1;
        return (reg_n > 64) ? 64 : reg_n;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // number of complete sets still waiting in the send queue
    function automatic int pend_sets();
        int c;
        c = 0;
        foreach (gen_pend[i]) if (gen_pend[i].last) c++;
        return c;
    endfunction

    // grow the ball D levels and return both counts
    function automatic void grow_ball(output ball_res_t res);
        int unsigned m, n, total, a, lvl, g, r, i, col, js, dr, sh, cnt, prv;
        int unsigned pw [64];
        bit early;
        m = eff_m();
        n = eff_n();
        total = m * n;
        a = reg_a % m;
        pw[0] = 1 % m;
        for (r = 1; r < n; r++) pw[r] = (pw[r-1] * a) % m;
        for (r = 0; r < 64; r++) ball_now[r] = '0;
        ball_now[0][0] = 1'b1;
        cnt = 1;
        prv = 1;
        early = 0;
        for (lvl = 1; lvl <= reg_d; lvl++) begin
            prv = cnt;
            for (r = 0; r < n; r++) ball_nxt[r] = ball_now[r];
            for (g = 0; g < gen_cnt; g++) begin
                col = gen_col[g] % m;
                js = gen_row[g] % n;
                for (r = 0; r < n; r++) begin
                    dr = (r + js) % n;
                    sh = (pw[r] * col) % m;
                    for (i = 0; i < m; i++)
                        if (ball_now[r][i]) ball_nxt[dr][(i + sh) % m] = 1'b1;
                end
            end
            cnt = 0;
            for (r = 0; r < n; r++) begin
                ball_now[r] = ball_nxt[r];
                cnt += $countones(ball_now[r]);
            end
            if (cnt == total && lvl < reg_d) begin
                early = 1;
                break;
            end
        end
        if (early) begin
            cnt = total;
            prv = total;
        end
        res.ball = cnt[14:0];
        res.prev = prv[14:0];
        res.cov = (cnt == total);
        res.err = drop_seen;
    endfunction

    function automatic void accept_gen(logic [13:0] e, logic last);
        int unsigned m;
        ball_res_t res;
        m = eff_m();
        if (e >= m * eff_n() || gen_cnt >= 32) begin
            drop_seen = 1;
        end else begin
            gen_col[gen_cnt] = e % m;
            gen_row[gen_cnt] = e / m;
            gen_cnt++;
        end
        if (last) begin
            grow_ball(res);
            ball_exp = {ball_exp, res};
            if (res.err) drops++;
            if (res.cov) covers++;
            sets_done++;
            gen_cnt = 0;
            drop_seen = 0;
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        gen_req_t nx;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accept_gen(s_tdata[13:0], s_tlast);
                sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the request
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (gen_pend.size() > 0) begin
                nx = gen_pend.pop_front();
                s_tdata <= {2'b00, nx.elem};
                s_tlast <= nx.last;
                s_tvalid <= 1'b1;
                tx_gap = rand_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        ball_res_t x;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ball_exp.size() == 0) begin
                    $error("result with no expectation: %h", m_tdata);
                    errors++;
                end else begin
                    x = ball_exp.pop_front();
                    if (m_tdata[14:0] !== x.ball) begin
                        $error("ball_count exp %0d got %0d", x.ball, m_tdata[14:0]);
                        errors++;
                    end
                    if (m_tdata[29:15] !== x.prev) begin
                        $error("prev_count exp %0d got %0d", x.prev, m_tdata[29:15]);
                        errors++;
                    end
                    if (m_tdata[30] !== x.cov) begin
                        $error("covered exp %0d got %0d", x.cov, m_tdata[30]);
                        errors++;
                    end
                    if (m_tdata[31] !== x.err) begin
                        $error("set_error exp %0d got %0d", x.err, m_tdata[31]);
                        errors++;
                    end
                end
            end
            // one long hold-off while several sets are still queued
            if (!hold_done && sets_done >= 20 && pend_sets() >= 2) begin
                hold_done = 1;
                hold_cnt = 30000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = rand_gap();
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= LIMIT) begin
            $display("cayley_ball_growth_counter_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_idle();
        do @(posedge aclk);
        while (gen_pend.size() != 0 || s_tvalid || ball_exp.size() != 0);
        // a non-final generator may still be loading
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MODULUS_M: reg_m = val;
            REG_ROWS_N:    reg_n = val[6:0];
            REG_TWIST_A:   reg_a = val[7:0];
            default:       reg_d = val[7:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(int m, int n, int a, int d);
        wait_idle();
        write_reg(REG_MODULUS_M, 9'(m));
        write_reg(REG_ROWS_N, 9'(n));
        write_reg(REG_TWIST_A, 9'(a));
        write_reg(REG_RADIUS_D, 9'(d));
    endtask

    task automatic push_gen(int e, bit last);
        gen_req_t r;
        r.elem = 14'(e);
        r.last = last;
        gen_pend = {gen_pend, r};
    endtask

    // k generators, mostly legal, the last one closes the set
    task automatic push_set(int k);
        int unsigned total;
        int e;
        total = eff_m() * eff_n();
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0)
                e = $urandom_range(0, 16383);
            else
                e = $urandom_range(0, total - 1);
            push_gen(e, i == k - 1);
        end
    endtask

    initial begin
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: trivial group
        push_gen(0, 1);
        set_cfg(5, 4, 2, 3);
        push_gen(1, 0);
        push_gen(5, 1);
        push_gen(16383, 0);
        push_gen(7, 1);
        set_cfg(5, 4, 2, 0);
        push_gen(3, 1);
        // change the group between loading and evaluation
        set_cfg(5, 4, 2, 4);
        push_gen(19, 0);
        push_gen(6, 0);
        set_cfg(3, 2, 2, 4);
        push_gen(1, 1);
        // out-of-range registers clamp
        set_cfg(0, 0, 0, 3);
        push_gen(0, 0);
        push_gen(1, 1);
        set_cfg(511, 127, 255, 2);
        push_gen(1, 0);
        push_gen(256, 1);
        set_cfg(256, 64, 1, 1);
        push_gen(16383, 1);
        set_cfg(2, 1, 255, 255);
        push_gen(0, 1);
        set_cfg(7, 3, 2, 255);
        push_gen(1, 0);
        push_gen(7, 1);

        // random phases; the sender pauses for every result at each phase change
        while (sent + gen_pend.size() < 540) begin
            k = $urandom_range(0, 9);
            if (k == 0)
                set_cfg($urandom_range(100, 511), $urandom_range(20, 127),
                        $urandom_range(0, 255), $urandom_range(0, 2));
            else
                set_cfg($urandom_range(1, 24), $urandom_range(1, 8),
                        $urandom_range(0, 255), $urandom_range(0, 14));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < 4; s++) begin
                if (k != 0 && $urandom_range(0, 11) == 0)
                    push_set($urandom_range(33, 36));
                else if (k == 0)
                    push_set($urandom_range(1, 3));
                else
                    push_set($urandom_range(1, 6));
            end
        end
        no_idle = 0;
        wait_idle();
        repeat (200) @(posedge aclk);

        $display("ran %0d generators in %0d sets over many group settings", sent, sets_done);
        $display("%0d sets fully covered, %0d sets flagged for dropped generators",
                 covers, drops);
        if (errors == 0) begin
            $display("cayley_ball_growth_counter_unit regression: pass");
        end else begin
            $display("cayley_ball_growth_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
